### rtl/buim_pkg.sv
package buim_pkg;

  localparam int DEFAULT_WINDOW_SLOTS = 16;

  localparam int TS_W     = 48;
  localparam int DUR_W    = 40;
  localparam int SUM_W    = 48;
  localparam int SMOOTH_W = 56;
  localparam int FRAC_W   = 16;
  localparam int WEIGHT_W = 16;
  localparam int PCT_W    = 15;
  localparam int CMD_W    = 2;

  localparam int QUO_W      = 15;
  localparam int DIVIDEND_W = 63;

  localparam logic [PCT_W-1:0]    PCT_FULL     = 15'd25600;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd9830;
  localparam logic [DUR_W-1:0]    DUR_MAX      = {DUR_W{1'b1}};

  localparam logic [CMD_W-1:0] CMD_FRAME_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_IDLE_BEGIN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_IDLE_END    = 2'd2;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;

endpackage

### rtl/buim_ram.sv
module buim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/buim_div.sv
module buim_div
  import buim_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [SUM_W-1:0]      divisor,
  output logic                  done,
  output logic [QUO_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] rem;
  logic [QUO_W-1:0] low;
  logic [SUM_W:0]   trial;
  logic             fits;

  // quotient is known to stay below 2^QUO_W, so the top bits start as the remainder
  assign trial = {rem, low[QUO_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      done     <= 1'b0;
      cnt      <= '0;
      quotient <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        cnt      <= CNT_W'(QUO_W);
        rem      <= dividend[DIVIDEND_W-1:QUO_W];
        low      <= dividend[QUO_W-1:0];
        quotient <= '0;
      end else if (running) begin
        rem      <= fits ? SUM_W'(trial - {1'b0, divisor}) : trial[SUM_W-1:0];
        quotient <= {quotient[QUO_W-2:0], fits};
        low      <= {low[QUO_W-2:0], 1'b0};
        cnt      <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/busy_idle_utilization_meter.sv
// Busy/idle utilization meter. Each input word is an event (tuser: 0 frame start,
// 1 idle begin, 2 idle end) with a 48-bit nanosecond timestamp; each event gives
// exactly one output word with the windowed busy percentage (1/256 percent), the
// smoothed busy frame time in ns, the idle flag and an order error flag. One event
// is processed at a time. Idle begin/end and rejected events pass from accept
// through the event step to the output step; the next word is taken once the block
// is back in its idle state. A frame start passes the event step, the frame steps
// S_FR1 to S_FR4, the 15-step bit-serial divider for the percentage and a final
// step before the output step; with a zero window total the divider is skipped.
// A stalled output holds the block in its output step. The per-slot idle/total
// durations sit in one synchronous RAM of WINDOW_SLOTS entries, read on every
// event and written back once per frame; per-slot valid bits make unwritten slots
// read as zero, so no clearing pass is needed after reset. The smoothing weight
// (Q0.16) may be written at any time the block is idle; cfg_ready is always high.
module busy_idle_utilization_meter
  import buim_pkg::*;
#(
  parameter int WINDOW_SLOTS = DEFAULT_WINDOW_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // timestamp[47:0]
  input  logic [CMD_W-1:0]      s_axis_tuser,  // cmd[1:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // busy_percent[14:0], smoothed_busy_ns[54:15], is_idle[55], order_error[56], zero[63:57]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [WEIGHT_W-1:0]   cfg_data
);

  localparam int PTR_W  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int SLOT_W = 2 * DUR_W;

  typedef enum logic [3:0] {
    S_IDLE, S_EVT, S_FR1, S_FR2, S_FR3, S_FR4, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t state;

  logic [CMD_W-1:0]    cmd_r;
  logic [TS_W-1:0]     ts_r;
  logic                err_r;
  logic [WEIGHT_W-1:0] weight;

  logic [TS_W-1:0]     frame_start_time;
  logic [TS_W-1:0]     idle_start_time;
  logic [DUR_W-1:0]    idle_acc;
  logic                idle_open;
  logic [PTR_W-1:0]    ptr;
  logic [SUM_W-1:0]    sum_idle;
  logic [SUM_W-1:0]    sum_total;
  logic [SMOOTH_W-1:0] smooth_q16;
  logic [PCT_W-1:0]    percent_held;
  logic [WINDOW_SLOTS-1:0] slot_valid;

  logic [TS_W-1:0]     total_r;
  logic                zero_frame;
  logic [DUR_W-1:0]    slot_idle_r;
  logic [DUR_W-1:0]    slot_total_r;
  logic [DUR_W-1:0]    old_idle_r;
  logic [DUR_W-1:0]    old_total_r;
  logic [DUR_W-1:0]    busy_x;
  logic [SMOOTH_W-1:0] diff_r;
  logic                up_r;
  logic [SMOOTH_W-1:0] prod_hi;
  logic [2*WEIGHT_W-1:0] prod_lo;
  logic [DIVIDEND_W-1:0] dividend;

  // ram
  logic              ram_we;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_rdata;

  // divider
  logic             div_start;
  logic             div_done;
  logic [QUO_W-1:0] div_q;

  // combinational helpers
  logic [TS_W-1:0]     idle_len;
  logic [TS_W:0]       idle_sum;
  logic [DUR_W-1:0]    idle_acc_next;
  logic [TS_W-1:0]     idle_min;
  logic [DUR_W-1:0]    slot_total;
  logic [DUR_W-1:0]    slot_idle;
  logic [TS_W-1:0]     busy_len;
  logic [SMOOTH_W-1:0] x_q16;
  logic [SUM_W-1:0]    busy_sum;
  logic [SMOOTH_W-1:0] weighted;
  logic                out_free;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign ram_re    = (state == S_EVT);
  assign ram_we    = (state == S_FR2);
  assign div_start = (state == S_FR4) && (sum_total != '0);

  always_comb begin
    idle_len      = ts_r - idle_start_time;
    idle_sum      = {{(TS_W + 1 - DUR_W){1'b0}}, idle_acc} + {1'b0, idle_len};
    idle_acc_next = (idle_sum[TS_W:DUR_W] != '0) ? DUR_MAX : idle_sum[DUR_W-1:0];

    idle_min   = ({{(TS_W - DUR_W){1'b0}}, idle_acc} < total_r)
                 ? {{(TS_W - DUR_W){1'b0}}, idle_acc} : total_r;
    slot_total = (total_r[TS_W-1:DUR_W] != '0) ? DUR_MAX : total_r[DUR_W-1:0];
    slot_idle  = (idle_min < {{(TS_W - DUR_W){1'b0}}, slot_total})
                 ? idle_min[DUR_W-1:0] : slot_total;
    busy_len   = total_r - idle_min;

    x_q16    = {busy_x, {FRAC_W{1'b0}}};
    busy_sum = (sum_idle <= sum_total) ? sum_total - sum_idle : '0;
    weighted = prod_hi + {{(SMOOTH_W - WEIGHT_W){1'b0}}, prod_lo[2*WEIGHT_W-1:WEIGHT_W]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      err_r            <= 1'b0;
      weight           <= WEIGHT_RESET;
      frame_start_time <= '0;
      idle_start_time  <= '0;
      idle_acc         <= '0;
      idle_open        <= 1'b0;
      ptr              <= '0;
      sum_idle         <= '0;
      sum_total        <= '0;
      smooth_q16       <= '0;
      percent_held     <= '0;
      slot_valid       <= '0;
      m_axis_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        weight <= cfg_data;
      end
      // in S_OUT a taken word is replaced by the next one below
      if (m_axis_tvalid && m_axis_tready && (state != S_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_r <= s_axis_tuser;
            ts_r  <= s_axis_tdata[TS_W-1:0];
            err_r <= 1'b0;
            state <= S_EVT;
          end
        end
        S_EVT: begin
          state <= S_OUT;
          unique case (cmd_r)
            CMD_FRAME_START: begin
              if (idle_open) begin
                err_r <= 1'b1;
              end else begin
                // slot read is issued this cycle
                total_r <= ts_r - frame_start_time;
                state   <= S_FR1;
              end
            end
            CMD_IDLE_BEGIN: begin
              if (idle_open) begin
                err_r <= 1'b1;
              end else begin
                idle_open       <= 1'b1;
                idle_start_time <= ts_r;
              end
            end
            CMD_IDLE_END: begin
              if (!idle_open) begin
                err_r <= 1'b1;
              end else begin
                idle_acc  <= idle_acc_next;
                idle_open <= 1'b0;
              end
            end
            default: begin
              err_r <= 1'b1;
            end
          endcase
        end
        S_FR1: begin
          slot_total_r <= slot_total;
          slot_idle_r  <= slot_idle;
          busy_x       <= (busy_len[TS_W-1:DUR_W] != '0) ? DUR_MAX : busy_len[DUR_W-1:0];
          zero_frame   <= (total_r == '0);
          // a slot never written since reset reads as zero
          old_idle_r   <= slot_valid[ptr] ? ram_rdata[SLOT_W-1:DUR_W] : '0;
          old_total_r  <= slot_valid[ptr] ? ram_rdata[DUR_W-1:0] : '0;
          state        <= S_FR2;
        end
        S_FR2: begin
          sum_idle  <= sum_idle - {{(SUM_W - DUR_W){1'b0}}, old_idle_r}
                       + {{(SUM_W - DUR_W){1'b0}}, slot_idle_r};
          sum_total <= sum_total - {{(SUM_W - DUR_W){1'b0}}, old_total_r}
                       + {{(SUM_W - DUR_W){1'b0}}, slot_total_r};
          slot_valid[ptr] <= 1'b1;
          up_r   <= (x_q16 >= smooth_q16);
          diff_r <= (x_q16 >= smooth_q16) ? x_q16 - smooth_q16 : smooth_q16 - x_q16;
          state  <= S_FR3;
        end
        S_FR3: begin
          prod_hi <= diff_r[SMOOTH_W-1:FRAC_W] * weight;
          prod_lo <= diff_r[FRAC_W-1:0] * weight;
          // busy * 25600 as three shifted terms
          dividend <= ({{(DIVIDEND_W - SUM_W){1'b0}}, busy_sum} << 14)
                      + ({{(DIVIDEND_W - SUM_W){1'b0}}, busy_sum} << 13)
                      + ({{(DIVIDEND_W - SUM_W){1'b0}}, busy_sum} << 10);
          state <= S_FR4;
        end
        S_FR4: begin
          if (!zero_frame) begin
            smooth_q16 <= up_r ? smooth_q16 + weighted : smooth_q16 - weighted;
          end
          state <= (sum_total != '0) ? S_DIV : S_FIN;
        end
        S_DIV: begin
          if (div_done) begin
            percent_held <= (div_q > PCT_FULL) ? PCT_FULL : div_q;
            state        <= S_FIN;
          end
        end
        S_FIN: begin
          ptr              <= (ptr == PTR_W'(WINDOW_SLOTS - 1)) ? '0 : ptr + 1'b1;
          frame_start_time <= ts_r;
          idle_acc         <= '0;
          state            <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {{(OUT_DATA_W - PCT_W - DUR_W - 2){1'b0}}, err_r, idle_open,
                              smooth_q16[SMOOTH_W-1:FRAC_W], percent_held};
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  buim_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(WINDOW_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ptr),
    .wdata({slot_idle_r, slot_total_r}),
    .re   (ram_re),
    .raddr(ptr),
    .rdata(ram_rdata)
  );

  buim_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(dividend),
    .divisor (sum_total),
    .done    (div_done),
    .quotient(div_q)
  );

endmodule

### rtl/buim_checker.sv
module buim_checker
  import buim_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  cfg_ready
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[PCT_W-1:0] <= PCT_FULL)
    else $error("busy percent above full scale");

  // one event in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word accepted while an event is in work");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready && cfg_ready)
    else $error("block not idle after reset");

endmodule

bind busy_idle_utilization_meter buim_checker u_buim_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .cfg_ready    (cfg_ready)
);
